[hdl/arm_pkg.sv]
// Package: shared types and constants for the address range merger.
`default_nettype none
package arm_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_MAX = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] area_start;
    logic [ADDR_W-1:0] area_end;
    logic              last_area;
  } area_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] merged_start;
    logic [ADDR_W-1:0] merged_end;
    logic              merged_last;
    logic              overflow;
  } merged_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT
  } arm_state_t;

  typedef enum logic [2:0] {
    CL_START_IN,
    CL_END_IN,
    CL_COVER,
    CL_ABUT_HI,
    CL_ABUT_LO,
    CL_APART
  } arm_class_t;

  // Classify range b against the growing merged range a.
  function automatic arm_class_t classify(input logic [ADDR_W-1:0] as_v,
                                          input logic [ADDR_W-1:0] ae_v,
                                          input logic [ADDR_W-1:0] bs_v,
                                          input logic [ADDR_W-1:0] be_v);
    logic start_in;
    logic end_in;
    arm_class_t cl;
    start_in = (as_v <= bs_v) && (ae_v >= bs_v);
    end_in   = (as_v <= be_v) && (ae_v >= be_v);
    if (start_in) cl = CL_START_IN;
    else if (end_in) cl = CL_END_IN;
    else if (bs_v <= as_v && be_v >= as_v && bs_v <= ae_v && be_v >= ae_v) cl = CL_COVER;
    else if (bs_v != ADDR_ZERO && ae_v == bs_v - 1'b1) cl = CL_ABUT_HI;
    else if (be_v != ADDR_MAX && as_v == be_v + 1'b1) cl = CL_ABUT_LO;
    else cl = CL_APART;
    return cl;
  endfunction
endpackage
`default_nettype wire

[hdl/arm_store.sv]
// Range store: dual-array memory with one write port and one registered read port.
`default_nettype none
module arm_store
  import arm_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [ADDR_W-1:0] wr_start,
  input  wire logic [ADDR_W-1:0] wr_end,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [ADDR_W-1:0] rd_start,
  output logic      [ADDR_W-1:0] rd_end
);
  logic [ADDR_W-1:0] starts [DEPTH];
  logic [ADDR_W-1:0] ends_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      starts[wr_addr]   <= wr_start;
      ends_mem[wr_addr] <= wr_end;
    end
    rd_start <= starts[rd_addr];
    rd_end   <= ends_mem[rd_addr];
  end
endmodule
`default_nettype wire

[hdl/address_range_merger.sv]
// Top level: loads address ranges, merges them in place, streams the result.
// Ranges load one word per cycle into a single-port-write, single-port-read
// memory. A word with last_area starts the merge: for each cursor position p
// the engine reads p, then streams the later entries one per cycle (one read
// per cycle, registered read data), folding each into the merged range
// held in registers and compacting the untouched ones down behind the cursor.
// A pass at cursor p repeats at the same cursor while it widened the range.
// Emission then reads each result, then presents it. Memory has no clearing
// pass: only entries below the fill count are ever read. The input is not
// ready during merge and emit.
`default_nettype none
module address_range_merger
  import arm_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire area_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output merged_out_t      out_data
);
  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);

  arm_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] cur, cur_next;     // cursor
  logic [CW-1:0] rdi, rdi_next;     // next index to read in a pass
  logic [CW-1:0] keep, keep_next;   // compaction write index
  logic          widened, widened_next;
  logic          rd_pend, rd_pend_next; // read data valid this cycle in pass
  logic [ADDR_W-1:0] as_r, as_next, ae_r, ae_next;
  merged_out_t   obuf, obuf_next;
  logic          ovalid, ovalid_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [ADDR_W-1:0] wr_start, wr_end, rd_start, rd_end;

  arm_store #(.DEPTH(MAX_RANGES), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_start(wr_start),
    .wr_end(wr_end), .rd_addr(rd_addr), .rd_start(rd_start), .rd_end(rd_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      ovalid  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      ovalid  <= ovalid_next;
      rd_pend <= rd_pend_next;
    end
    cur     <= cur_next;
    rdi     <= rdi_next;
    keep    <= keep_next;
    widened <= widened_next;
    as_r    <= as_next;
    ae_r    <= ae_next;
    obuf    <= obuf_next;
  end

  arm_class_t cl;
  assign cl = classify(as_r, ae_r, rd_start, rd_end);

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    cur_next     = cur;
    rdi_next     = rdi;
    keep_next    = keep;
    widened_next = widened;
    rd_pend_next = 1'b0;
    as_next      = as_r;
    ae_next      = ae_r;
    obuf_next    = obuf;
    ovalid_next  = ovalid && !out_ready;
    wr_en        = 1'b0;
    wr_addr      = AW'(count);
    wr_start     = in_data.area_start;
    wr_end       = in_data.area_end;
    rd_addr      = AW'(rdi);
    in_ready     = (state == ST_LOAD);
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          if (count < CNT_MAX) begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (in_data.last_area) begin
            // Start merging at cursor 0 with the count after this word.
            cur_next   = '0;
            rdi_next   = '0;
            state_next = ST_PASS_RD;
          end
        end
      end
      ST_PASS_RD: begin
        // Issue read of the cursor entry, or finish when cursor reaches count.
        if (cur >= count) begin
          rdi_next   = '0;
          state_next = ST_EMIT_RD;
        end else begin
          rd_addr      = AW'(cur);
          rdi_next     = cur + 1'b1;
          keep_next    = cur + 1'b1;
          widened_next = 1'b0;
          state_next   = ST_PASS;
        end
      end
      ST_PASS: begin
        // First cycle holds the cursor entry; later cycles hold candidates.
        if (!rd_pend) begin
          as_next = rd_start;
          ae_next = rd_end;
        end else begin
          case (cl)
            CL_START_IN: begin
              if (!((as_r <= rd_end) && (ae_r >= rd_end))) begin
                widened_next = 1'b1;
                ae_next      = rd_end;
              end
            end
            CL_END_IN, CL_ABUT_LO: begin
              widened_next = 1'b1;
              as_next      = rd_start;
            end
            CL_COVER: begin
              widened_next = 1'b1;
              as_next      = rd_start;
              ae_next      = rd_end;
            end
            CL_ABUT_HI: begin
              widened_next = 1'b1;
              ae_next      = rd_end;
            end
            default: begin
              // Move the untouched range down behind the cursor.
              wr_en     = 1'b1;
              wr_addr   = AW'(keep);
              wr_start  = rd_start;
              wr_end    = rd_end;
              keep_next = keep + 1'b1;
            end
          endcase
        end
        if (rdi < count) begin
          rd_addr      = AW'(rdi);
          rdi_next     = rdi + 1'b1;
          rd_pend_next = 1'b1;
        end else if (!rd_pend) begin
          state_next = ST_PASS_END;
        end else begin
          state_next = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        // Write back the merged range; shrink the list; repeat or advance.
        wr_en      = 1'b1;
        wr_addr    = AW'(cur);
        wr_start   = as_r;
        wr_end     = ae_r;
        count_next = keep;
        if (!widened) cur_next = cur + 1'b1;
        state_next = ST_PASS_RD;
      end
      ST_EMIT_RD: begin
        if (rdi >= count) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_LOAD;
        end else if (!ovalid || out_ready) begin
          rd_addr    = AW'(rdi);
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        obuf_next.merged_start = rd_start;
        obuf_next.merged_end   = rd_end;
        obuf_next.merged_last  = (rdi + 1'b1 == count);
        obuf_next.overflow     = ovf;
        ovalid_next = 1'b1;
        rdi_next    = rdi + 1'b1;
        state_next  = ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assign out_valid = ovalid;
  assign out_data  = obuf;

  // Input is never taken while a merge or emission is under way.
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == ST_LOAD)) else $error("input ready outside load");
  // The fill count never exceeds capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("fill count beyond capacity");
  // A pending result is not overwritten before it is taken.
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result lost under stall");
endmodule
`default_nettype wire

[bench/tb_address_range_merger.sv]
// Testbench for address_range_merger: directed and random range lists against a predictor.
`default_nettype none
module tb_address_range_merger;
  import arm_pkg::*;

  localparam int DEPTH = 16;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  area_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  merged_out_t out_data;

  address_range_merger #(.MAX_RANGES(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: the list as the block should hold it.
  logic [ADDR_W-1:0] held_starts [DEPTH];
  logic [ADDR_W-1:0] held_ends [DEPTH];
  int                held_count;
  bit                dropped_seen;

  merged_out_t merged_q [$];
  int          mismatches;
  int          burst_left;
  int          stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("address_range_merger test failed");
    $finish;
  end

  // One pass at cursor p: fold later ranges into the growing range, compact the rest.
  task automatic fold_pass(input int p, inout int n, output bit widened);
    logic [ADDR_W-1:0] as_v, ae_v, bs_v, be_v;
    int keep;
    bit s_in, e_in;
    as_v = held_starts[p];
    ae_v = held_ends[p];
    keep = p + 1;
    widened = 1'b0;
    for (int c = p + 1; c < n; c++) begin
      bs_v = held_starts[c];
      be_v = held_ends[c];
      s_in = (as_v <= bs_v) && (ae_v >= bs_v);
      e_in = (as_v <= be_v) && (ae_v >= be_v);
      if (s_in) begin
        if (!e_in) begin
          widened = 1'b1;
          ae_v = be_v;
        end
      end else if (e_in) begin
        widened = 1'b1;
        as_v = bs_v;
      end else if (bs_v <= as_v && be_v >= as_v && bs_v <= ae_v && be_v >= ae_v) begin
        widened = 1'b1;
        as_v = bs_v;
        ae_v = be_v;
      end else if (bs_v != ADDR_ZERO && ae_v == bs_v - 1) begin
        widened = 1'b1;
        ae_v = be_v;
      end else if (be_v != ADDR_MAX && as_v == be_v + 1) begin
        widened = 1'b1;
        as_v = bs_v;
      end else begin
        held_starts[keep] = bs_v;
        held_ends[keep] = be_v;
        keep++;
      end
    end
    held_starts[p] = as_v;
    held_ends[p] = ae_v;
    n = keep;
  endtask

  // Store one accepted word; on the last word merge and queue the merged ranges.
  task automatic predict_word(input area_in_t w);
    int n, p;
    bit wid;
    merged_out_t r;
    if (held_count < DEPTH) begin
      held_starts[held_count] = w.area_start;
      held_ends[held_count] = w.area_end;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (w.last_area) begin
      n = held_count;
      p = 0;
      while (p < n) begin
        fold_pass(p, n, wid);
        if (!wid) p++;
      end
      for (int k = 0; k < n; k++) begin
        r.merged_start = held_starts[k];
        r.merged_end = held_ends[k];
        r.merged_last = (k + 1 == n);
        r.overflow = dropped_seen;
        merged_q.push_back(r);
      end
      held_count = 0;
      dropped_seen = 1'b0;
    end
  endtask

  // Send one word; gaps fall only between bursts, valid holds until accepted.
  task automatic send_range(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] e,
                            input bit last);
    int gap;
    area_in_t w;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.area_start = s;
    w.area_end = e;
    w.last_area = last;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
  endtask

  // Hold off the sender until every queued result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (merged_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern changes mode now and then; check each taken word.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (merged_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result start=%h end=%h last=%b ovf=%b",
                     out_data.merged_start, out_data.merged_end,
                     out_data.merged_last, out_data.overflow);
        end else begin
          if (out_data !== merged_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h..%h last=%b ovf=%b got %h..%h last=%b ovf=%b",
                       merged_q[0].merged_start, merged_q[0].merged_end,
                       merged_q[0].merged_last, merged_q[0].overflow,
                       out_data.merged_start, out_data.merged_end,
                       out_data.merged_last, out_data.overflow);
          end
          void'(merged_q.pop_front());
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Extremes, each way of touching, limits of abutting, reversed and single ranges.
  task automatic test_directed();
    send_range(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_range(32'h100, 32'h1FF, 1'b0);   // base
    send_range(32'h180, 32'h2FF, 1'b0);   // start inside: widen up
    send_range(32'h080, 32'h120, 1'b0);   // end inside: widen down
    send_range(32'h150, 32'h160, 1'b0);   // contained only
    send_range(32'h000, 32'h3FF, 1'b1);   // covers all
    send_range(32'h1000, 32'h1FFF, 1'b0);
    send_range(32'h2000, 32'h20FF, 1'b0); // abuts above
    send_range(32'h0F00, 32'h0FFF, 1'b0); // abuts below
    send_range(32'h5000, 32'h5001, 1'b1); // apart
    drain_results();
    send_range(32'h0000_0000, 32'h0000_0010, 1'b0);
    send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1); // no abut across the wrap
    send_range(32'h0000_0300, 32'h0000_0200, 1'b0); // reversed
    send_range(32'h0000_0250, 32'h0000_0260, 1'b0);
    send_range(32'h0000_0100, 32'h0000_01FF, 1'b1);
    send_range(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_range(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
  endtask

  // Fill past capacity, including a last word that is itself dropped.
  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++)
      send_range(32'h10 * i * 2, 32'h10 * i * 2 + 5, 1'b0);
    send_range(32'h7777_0000, 32'h7777_0001, 1'b1);
    drain_results();
    for (int i = 0; i < DEPTH + 3; i++)
      send_range(32'h1000 - 8 * i, 32'h1000 - 8 * i + 3, i == DEPTH + 2);
  endtask

  // Random lists: mostly clustered ranges so merges cascade, some wide noise.
  task automatic test_random();
    int sent, len, mode;
    logic [ADDR_W-1:0] base, s, e;
    sent = 0;
    while (sent < 115) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: base = 32'h0;
        1: base = 32'hFFFF_FF00;
        default: base = $urandom;
      endcase
      for (int i = 0; i < len; i++) begin
        if (mode == 0) begin
          s = $urandom;
          e = $urandom;
        end else begin
          s = base + $urandom_range(0, 96);
          e = ($urandom_range(0, 15) == 0) ? s - $urandom_range(1, 8)
                                            : s + $urandom_range(0, 24);
        end
        send_range(s, e, i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    held_count = 0;
    dropped_seen = 1'b0;
    mismatches = 0;
    burst_left = 0;
    stall_mode = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && merged_q.size() == 0) begin
      $display("address_range_merger test passed");
    end else begin
      $display("address_range_merger test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
